// ----- rtl/core/tchb_pkg.sv -----
// tchb_pkg: shared types, codes and defaults of the three channel histogram binner
package tchb_pkg;

  localparam int MAX_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BINS_REG_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_THETA_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THETA_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MU_LO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MU_HI    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BINS     = 3'd6;

  localparam logic [1:0] MODE_THETA = 2'd0;
  localparam logic [1:0] MODE_MU    = 2'd1;
  localparam logic [1:0] MODE_SIGMA = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic signed [31:0]   EDGE_LO_RST = 32'sd0;
  localparam logic signed [31:0]   EDGE_HI_RST = 32'sd65536;
  localparam logic [BINS_REG_W-1:0] BINS_RST   = 9'd64;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  sample_value;
  } in_t;

  typedef struct packed {
    logic [7:0]          bin_number;
    logic [31:0]         count_after;
    logic signed [63:0]  channel_sum;
    logic                range_flag;
  } out_t;

endpackage

// ----- rtl/core/three_channel_histogram_binner.sv -----
// three_channel_histogram_binner: top level of the three channel histogram binner
// Each word on in_i is taken when start_i is high and busy_o is low; exactly one result word
// follows on result_o with done_o high for a single cycle, and it cannot be held off. An
// in-range sample passes through the setup, multiply, divide, read and update states; the
// one-bit-a-cycle divider maps the sample onto its bin. An out-of-range sample or an invalid
// range skips the divider, and mode 3 ends in the setup state. After reset all 3*MAX_BINS
// entries of the bin count memory are cleared one entry a cycle with busy_o high;
// configuration writes are taken at all times.
module three_channel_histogram_binner #(
  parameter int MAX_BINS    = tchb_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = tchb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  tchb_pkg::in_t                       in_i,
  output logic                                done_o,
  output tchb_pkg::out_t                      result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tchb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tchb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tchb_pkg::*;

  localparam int BW    = $clog2(MAX_BINS + 1);
  localparam int BNW   = $clog2(MAX_BINS);
  localparam int PW    = 32 + BW;
  localparam int DEPTH = 3 * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = (BW > BINS_REG_W) ? BW : BINS_REG_W;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_MULT   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_UPDATE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [31:0]    theta_lo_q, theta_hi_q, mu_lo_q, mu_hi_q, sigma_lo_q, sigma_hi_q;
  logic [BINS_REG_W-1:0] bins_q;
  logic                  cfg_we;

  // running sums
  logic signed [63:0] theta_sum_q, mu_sum_q, sigma_sum_q;
  logic signed [63:0] sum_sel;
  logic [64:0]        sum_wide;
  logic signed [63:0] sum_new;

  // item datapath
  logic [1:0]         mode_q, mode_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] lo_s, hi_s;
  logic [32:0]        diff_wide, span_wide;
  logic [31:0]        diff_q, diff_d;
  logic [31:0]        span_q, span_d;
  logic [BW-1:0]      bins_eff_q, bins_eff_d;
  logic [BW-1:0]      bins_eff_s;
  logic [BNW-1:0]     bin_q, bin_d;
  logic               flag_q, flag_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic               dstart_q, dstart_d;
  logic               div_done;
  logic [BW-1:0]      div_quot;
  logic signed [63:0] sum_res_q, sum_res_d;

  // result
  out_t res_q, res_d;
  logic done_q, done_d;

  // count memory
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] mem_rdata_q;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [AW-1:0]          mem_addr;
  logic [AW-1:0]          mem_waddr;
  logic                   mem_we;
  logic [AW-1:0]          clr_q, clr_d;
  logic [31:0]            cnt32;
  logic                   accept;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_lo_q <= EDGE_LO_RST;
      theta_hi_q <= EDGE_HI_RST;
      mu_lo_q    <= EDGE_LO_RST;
      mu_hi_q    <= EDGE_HI_RST;
      sigma_lo_q <= EDGE_LO_RST;
      sigma_hi_q <= EDGE_HI_RST;
      bins_q     <= BINS_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_THETA_LO: theta_lo_q <= cfg_data_i;
        REG_THETA_HI: theta_hi_q <= cfg_data_i;
        REG_MU_LO:    mu_lo_q    <= cfg_data_i;
        REG_MU_HI:    mu_hi_q    <= cfg_data_i;
        REG_SIGMA_LO: sigma_lo_q <= cfg_data_i;
        REG_SIGMA_HI: sigma_hi_q <= cfg_data_i;
        REG_BINS:     bins_q     <= cfg_data_i[BINS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // channel selection
  always_comb begin
    case (mode_q)
      MODE_THETA: begin
        lo_s    = theta_lo_q;
        hi_s    = theta_hi_q;
        sum_sel = theta_sum_q;
      end
      MODE_MU: begin
        lo_s    = mu_lo_q;
        hi_s    = mu_hi_q;
        sum_sel = mu_sum_q;
      end
      default: begin
        lo_s    = sigma_lo_q;
        hi_s    = sigma_hi_q;
        sum_sel = sigma_sum_q;
      end
    endcase
  end

  always_comb begin
    if (bins_q == '0) begin
      bins_eff_s = BW'(1);
    end else if (CMPW'(bins_q) > CMPW'(MAX_BINS)) begin
      bins_eff_s = BW'(MAX_BINS);
    end else begin
      bins_eff_s = BW'(bins_q);
    end
  end

  assign diff_wide = {val_q[31], val_q} - {lo_s[31], lo_s};
  assign span_wide = {hi_s[31], hi_s} - {lo_s[31], lo_s};

  // saturating 64-bit sum
  assign sum_wide = {sum_sel[63], sum_sel} + {{33{val_q[31]}}, val_q};
  always_comb begin
    if (sum_wide[64] != sum_wide[63]) begin
      sum_new = sum_wide[64] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new = sum_wide[63:0];
    end
  end

  assign mem_addr = AW'(mode_q) * AW'(MAX_BINS) + AW'(bin_q);
  assign cnt_new  = (&mem_rdata_q) ? mem_rdata_q : mem_rdata_q + COUNT_WIDTH'(1);

  if (COUNT_WIDTH > 32) begin : g_cnt_wide
    assign cnt32 = (|cnt_new[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cnt_new[31:0];
  end else begin : g_cnt_narrow
    assign cnt32 = 32'(cnt_new);
  end

  tchb_divider #(
    .QuotWidth (BW)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart_q),
    .numer_i (prod_q),
    .denom_i (span_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    val_d      = val_q;
    diff_d     = diff_q;
    span_d     = span_q;
    bins_eff_d = bins_eff_q;
    bin_d      = bin_q;
    flag_d     = flag_q;
    prod_d     = prod_q;
    dstart_d   = 1'b0;
    sum_res_d  = sum_res_q;
    res_d      = res_q;
    done_d     = 1'b0;
    clr_d      = clr_q;
    mem_we     = 1'b0;
    mem_waddr  = mem_addr;
    mem_wdata  = cnt_new;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_d  = in_i.mode;
          val_d   = in_i.sample_value;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        bins_eff_d = bins_eff_s;
        diff_d     = diff_wide[31:0];
        span_d     = span_wide[31:0];
        if (hi_s <= lo_s) begin
          bin_d  = '0;
          flag_d = 1'b1;
        end else if (val_q < lo_s) begin
          bin_d  = '0;
          flag_d = 1'b1;
        end else if (val_q > hi_s) begin
          bin_d  = BNW'(bins_eff_s - BW'(1));
          flag_d = 1'b1;
        end else begin
          flag_d = 1'b0;
        end
        if (mode_q == MODE_NONE) begin
          res_d.bin_number  = '0;
          res_d.count_after = '0;
          res_d.channel_sum = '0;
          res_d.range_flag  = 1'b1;
          done_d            = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        prod_d    = PW'(diff_q) * PW'(bins_eff_q);
        sum_res_d = sum_new;
        if (flag_q) begin
          state_d = ST_READ;
        end else begin
          dstart_d = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_quot >= bins_eff_q) begin
            bin_d = BNW'(bins_eff_q - BW'(1));
          end else begin
            bin_d = BNW'(div_quot);
          end
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        mem_we            = 1'b1;
        res_d.bin_number  = 8'(bin_q);
        res_d.count_after = cnt32;
        res_d.channel_sum = sum_res_q;
        res_d.range_flag  = flag_q;
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      done_q      <= 1'b0;
      dstart_q    <= 1'b0;
      theta_sum_q <= '0;
      mu_sum_q    <= '0;
      sigma_sum_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      dstart_q <= dstart_d;
      if (state_q == ST_MULT) begin
        case (mode_q)
          MODE_THETA: theta_sum_q <= sum_new;
          MODE_MU:    mu_sum_q    <= sum_new;
          MODE_SIGMA: sigma_sum_q <= sum_new;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    val_q      <= val_d;
    diff_q     <= diff_d;
    span_q     <= span_d;
    bins_eff_q <= bins_eff_d;
    bin_q      <= bin_d;
    flag_q     <= flag_d;
    prod_q     <= prod_d;
    sum_res_q  <= sum_res_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("busy not raised after a word was taken");

  a_done_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_UPDATE) || ($past(state_q) == ST_SETUP))
    else $error("result strobe without a finished update");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.range_flag) |-> (result_o.count_after != '0))
    else $error("in-range update returned a zero count");

endmodule

// ----- rtl/core/tchb_divider.sv -----
// tchb_divider: restoring radix-2 divider producing a short quotient, one bit a cycle
module tchb_divider #(
  parameter int QuotWidth = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [32+QuotWidth-1:0] numer_i,
  input  logic [31:0]             denom_i,
  output logic                    done_o,
  output logic [QuotWidth-1:0]    quot_o
);
  import tchb_pkg::*;

  localparam int SW = (QuotWidth > 1) ? $clog2(QuotWidth) : 1;

  logic [31:0]          rem_q, rem_d;
  logic [QuotWidth-1:0] quo_q, quo_d;
  logic [SW-1:0]        step_q, step_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [32:0]          trial;
  logic [32:0]          trial_sub;
  logic                 ge;

  assign trial     = {rem_q, quo_q[QuotWidth-1]};
  assign trial_sub = trial - {1'b0, denom_i};
  assign ge        = (trial >= {1'b0, denom_i});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = numer_i[32+QuotWidth-1:QuotWidth];
      quo_d  = numer_i[QuotWidth-1:0];
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = ge ? trial_sub[31:0] : trial[31:0];
      quo_d  = {quo_q[QuotWidth-2:0], ge};
      step_d = step_q + SW'(1);
      if (step_q == SW'(QuotWidth - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- tb/three_channel_histogram_binner_checker.sv -----
`timescale 1ns / 100ps
// three_channel_histogram_binner_checker: bin, count and sum predictor that checks each result word
module three_channel_histogram_binner_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  tchb_pkg::in_t                   in_i,
  input  logic                            done_i,
  input  tchb_pkg::out_t                  result_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [tchb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tchb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              pending_o,
  output int                              errors_o
);
  import tchb_pkg::*;

  localparam int NUM_CHANNELS = 3;

  logic signed [63:0]    low_edge    [NUM_CHANNELS];
  logic signed [63:0]    high_edge   [NUM_CHANNELS];
  logic signed [63:0]    running_sum [NUM_CHANNELS];
  logic [BINS_REG_W-1:0] bins_setting;
  logic [31:0]           bin_tally   [NUM_CHANNELS*MAX_BINS_DEF];
  out_t                  binned_results [$];
  int                    mismatch_cnt = 0;

  assign errors_o = mismatch_cnt;

  function automatic out_t bin_sample(in_t word);
    logic signed [63:0] val;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [63:0]        offset;
    logic [63:0]        span;
    logic [63:0]        nbins;
    logic [63:0]        bin;
    int                 ch;
    int                 slot;
    out_t               res;
    res = '0;
    if (word.mode == MODE_NONE) begin
      res.range_flag = 1'b1;
      return res;
    end
    ch  = int'(word.mode);
    val = 64'(signed'(word.sample_value));
    lo  = low_edge[ch];
    hi  = high_edge[ch];
    if (bins_setting == '0) begin
      nbins = 64'd1;
    end else if (bins_setting > MAX_BINS_DEF) begin
      nbins = 64'(MAX_BINS_DEF);
    end else begin
      nbins = 64'(bins_setting);
    end
    if (hi <= lo) begin
      bin = '0;
      res.range_flag = 1'b1;
    end else if (val < lo) begin
      bin = '0;
      res.range_flag = 1'b1;
    end else if (val > hi) begin
      bin = nbins - 64'd1;
      res.range_flag = 1'b1;
    end else begin
      offset = val - lo;
      span   = hi - lo;
      bin    = (offset * nbins) / span;
      if (bin >= nbins) begin
        bin = nbins - 64'd1;
      end
    end
    slot = ch * MAX_BINS_DEF + int'(bin);
    if (bin_tally[slot] != '1) begin
      bin_tally[slot] = bin_tally[slot] + 32'd1;
    end
    if (val > 0 && running_sum[ch] > SUM_MAX - val) begin
      running_sum[ch] = SUM_MAX;
    end else if (val < 0 && running_sum[ch] < SUM_MIN - val) begin
      running_sum[ch] = SUM_MIN;
    end else begin
      running_sum[ch] = running_sum[ch] + val;
    end
    res.bin_number  = bin[7:0];
    res.count_after = bin_tally[slot];
    res.channel_sum = running_sum[ch];
    return res;
  endfunction

  function automatic void note_mismatch(string what, out_t want, out_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t mismatch, %s: expected bin %0d count %0d sum %0d flag %0b", $time, what,
               want.bin_number, want.count_after, want.channel_sum, want.range_flag);
      $display("    got bin %0d count %0d sum %0d flag %0b",
               got.bin_number, got.count_after, got.channel_sum, got.range_flag);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        low_edge[c]    = 64'(EDGE_LO_RST);
        high_edge[c]   = 64'(EDGE_HI_RST);
        running_sum[c] = '0;
      end
      foreach (bin_tally[i]) begin
        bin_tally[i] = '0;
      end
      bins_setting = BINS_RST;
      binned_results.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (binned_results.size() == 0) begin
          note_mismatch("result word with no sample pending", '0, result_i);
        end else begin
          want = binned_results.pop_front();
          if (result_i.bin_number  !== want.bin_number  ||
              result_i.count_after !== want.count_after ||
              result_i.channel_sum !== want.channel_sum ||
              result_i.range_flag  !== want.range_flag) begin
            note_mismatch("wrong result word", want, result_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        binned_results.insert(binned_results.size(), bin_sample(in_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_THETA_LO: begin
            low_edge[MODE_THETA] = 64'(signed'(cfg_data_i));
          end
          REG_THETA_HI: begin
            high_edge[MODE_THETA] = 64'(signed'(cfg_data_i));
          end
          REG_MU_LO: begin
            low_edge[MODE_MU] = 64'(signed'(cfg_data_i));
          end
          REG_MU_HI: begin
            high_edge[MODE_MU] = 64'(signed'(cfg_data_i));
          end
          REG_SIGMA_LO: begin
            low_edge[MODE_SIGMA] = 64'(signed'(cfg_data_i));
          end
          REG_SIGMA_HI: begin
            high_edge[MODE_SIGMA] = 64'(signed'(cfg_data_i));
          end
          REG_BINS: begin
            bins_setting = cfg_data_i[BINS_REG_W-1:0];
          end
          default: begin
          end
        endcase
      end
      pending_o <= binned_results.size();
    end
  end

endmodule

// ----- tb/three_channel_histogram_binner_tb.sv -----
`timescale 1ns / 100ps
// three_channel_histogram_binner_tb: sample and register stimulus with the final verdict
module three_channel_histogram_binner_tb;
  import tchb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int TAIL_CYCLES     = 24;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 240;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  in_t                   sample_word = '0;
  logic                  done;
  out_t                  result_word;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  int                    pending;
  int                    errors;
  int                    idle_pct    = 0;

  logic signed [31:0]    lo_edge [3] = '{EDGE_LO_RST, EDGE_LO_RST, EDGE_LO_RST};
  logic signed [31:0]    hi_edge [3] = '{EDGE_HI_RST, EDGE_HI_RST, EDGE_HI_RST};
  logic [BINS_REG_W-1:0] bins_word   = BINS_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  three_channel_histogram_binner uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .in_i        (sample_word),
    .done_o      (done),
    .result_o    (result_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  three_channel_histogram_binner_checker bin_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .in_i        (sample_word),
    .done_i      (done),
    .result_i    (result_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  task automatic send_word(input logic [1:0] mode, input logic [31:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    sample_word <= {mode, value};
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting();
    write_reg(REG_THETA_LO, lo_edge[MODE_THETA]);
    write_reg(REG_THETA_HI, hi_edge[MODE_THETA]);
    write_reg(REG_MU_LO, lo_edge[MODE_MU]);
    write_reg(REG_MU_HI, hi_edge[MODE_MU]);
    write_reg(REG_SIGMA_LO, lo_edge[MODE_SIGMA]);
    write_reg(REG_SIGMA_HI, hi_edge[MODE_SIGMA]);
    write_reg(REG_BINS, 32'(bins_word));
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic signed [63:0] span64;
    logic signed [63:0] pick;
    logic signed [31:0] swap_tmp;
    logic [1:0]         m;
    int                 r;
    int                 shape;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset ranges: unit range, 64 bins
    send_word(MODE_THETA, 32'sd0);
    send_word(MODE_THETA, 32'sd65536);
    send_word(MODE_THETA, 32'sd65535);
    send_word(MODE_THETA, 32'sd32768);
    send_word(MODE_THETA, -32'sd1);
    send_word(MODE_THETA, 32'sd65537);
    send_word(MODE_MU, 32'h7FFF_FFFF);
    send_word(MODE_SIGMA, 32'h8000_0000);
    send_word(MODE_SIGMA, 32'sd40000);
    send_word(MODE_SIGMA, 32'sd40000);
    send_word(MODE_NONE, 32'h5A5A_A5A5);
    settle();

    // full theta range, empty mu range, reversed sigma range
    lo_edge   = '{32'h8000_0000, 32'sd256, 32'sd5};
    hi_edge   = '{32'h7FFF_FFFF, 32'sd256, -32'sd5};
    bins_word = 9'd256;
    load_setting();
    send_word(MODE_THETA, 32'h8000_0000);
    send_word(MODE_THETA, 32'h7FFF_FFFF);
    send_word(MODE_THETA, 32'sd0);
    send_word(MODE_THETA, -32'sd1);
    send_word(MODE_MU, 32'sd256);
    send_word(MODE_SIGMA, 32'sd0);
    settle();

    // zero bins behaves as one
    lo_edge   = '{-32'sd65536, -32'sd65536, -32'sd65536};
    hi_edge   = '{32'sd65536, 32'sd65536, 32'sd65536};
    bins_word = 9'd0;
    load_setting();
    send_word(MODE_THETA, 32'sd0);
    send_word(MODE_SIGMA, 32'sd65536);
    send_word(MODE_MU, -32'sd65536);
    settle();

    // oversize bin count clamps to the maximum
    lo_edge   = '{-32'sd1000, -32'sd1000, -32'sd1000};
    hi_edge   = '{32'sd1000, 32'sd1000, 32'sd1000};
    bins_word = 9'h1FF;
    load_setting();
    send_word(MODE_MU, 32'sd999);
    send_word(MODE_MU, 32'sd1000);
    send_word(MODE_THETA, -32'sd1000);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_pct = (phase < 2) ? 17 : (phase < 4) ? 50 : 0;
      for (int c = 0; c < 3; c++) begin
        shape      = $urandom_range(0, 9);
        lo_edge[c] = $urandom;
        hi_edge[c] = $urandom;
        if (shape == 0) begin
          if (hi_edge[c] > lo_edge[c]) begin
            swap_tmp   = lo_edge[c];
            lo_edge[c] = hi_edge[c];
            hi_edge[c] = swap_tmp;
          end
        end else if (shape == 1) begin
          lo_edge[c] = 32'h8000_0000;
          hi_edge[c] = 32'h7FFF_FFFF;
        end else if (shape < 5) begin
          lo_edge[c] = 32'($urandom_range(0, 2097152)) - 32'sd1048576;
          hi_edge[c] = lo_edge[c] + 32'($urandom_range(1, 2000));
        end else if (lo_edge[c] > hi_edge[c]) begin
          swap_tmp   = lo_edge[c];
          lo_edge[c] = hi_edge[c];
          hi_edge[c] = swap_tmp;
        end
      end
      bins_word = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(1, 8)) : 9'($urandom);
      load_setting();

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        r    = $urandom_range(0, 99);
        m    = 2'($urandom_range(0, 2));
        pick = 64'(signed'($urandom));
        if (r < 5) begin
          m = MODE_NONE;
        end else if (r >= 15 && r < 25) begin
          case ($urandom_range(0, 3))
            0: pick = 64'(lo_edge[m]);
            1: pick = 64'(lo_edge[m]) - 64'sd1;
            2: pick = 64'(hi_edge[m]);
            default: pick = 64'(hi_edge[m]) + 64'sd1;
          endcase
        end else if (r >= 25 && hi_edge[m] > lo_edge[m]) begin
          span64 = 64'(hi_edge[m]) - 64'(lo_edge[m]);
          pick   = 64'(lo_edge[m]) + 64'({$urandom, $urandom} % (span64 + 64'sd1));
        end
        send_word(m, pick[31:0]);
        if ($urandom_range(0, 199) == 0) begin
          settle();
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tchb_pkg.sv
rtl/core/tchb_divider.sv
rtl/core/three_channel_histogram_binner.sv
tb/three_channel_histogram_binner_checker.sv
tb/three_channel_histogram_binner_tb.sv
